// ===== rtl/mhfs_pkg.sv =====
package mhfs_pkg;

  localparam int MaxRes = 3;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef enum logic [2:0] {
    K_NAME    = 3'd0,
    K_VALUE   = 3'd1,
    K_DONE    = 3'd2,
    K_DISCARD = 3'd3,
    K_DROPPED = 3'd4,
    K_ENDED   = 3'd5
  } kind_t;

  typedef enum logic [7:0] {
    PH_NAME     = 8'b0000_0001,
    PH_NAME_CR  = 8'b0000_0010,
    PH_COLON    = 8'b0000_0100,
    PH_COLON_CR = 8'b0000_1000,
    PH_VALUE    = 8'b0001_0000,
    PH_VALUE_CR = 8'b0010_0000,
    PH_CRLF     = 8'b0100_0000,
    PH_FOLD     = 8'b1000_0000
  } phase_t;

  // results produced by one request, slot 0 first
  typedef struct packed {
    logic [1:0]                    cnt;
    kind_t [MaxRes-1:0]            kind;
    logic  [MaxRes-1:0][7:0]       data;
  } bundle_t;

endpackage

// ===== rtl/mhfs_in_if.sv =====
interface mhfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== rtl/mhfs_out_if.sv =====
interface mhfs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output result_kind, output out_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input result_kind, input out_byte, input last_of_run,
                  output ready);
endinterface

// ===== rtl/mhfs_front.sv =====
module mhfs_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             take,
  input  logic [7:0]       text_byte,
  input  logic             end_of_text,
  output logic             push,
  output mhfs_pkg::bundle_t bundle
);
  import mhfs_pkg::*;

  phase_t phase_r, phase_nxt;
  logic   has_r, has_nxt;
  logic   ml_r;

  function automatic bundle_t add(bundle_t bi, kind_t k, logic [7:0] d);
    bundle_t bo;
    bo = bi;
    bo.kind[bi.cnt] = k;
    bo.data[bi.cnt] = d;
    bo.cnt = bi.cnt + 2'd1;
    return bo;
  endfunction

  always_comb begin
    logic do_name;
    logic do_value;
    logic blank;
    bundle_t b;
    do_name   = 1'b0;
    do_value  = 1'b0;
    blank     = (text_byte == ChSpace) || (text_byte == ChTab);
    b         = '0;
    phase_nxt = phase_r;
    has_nxt   = has_r;
    if (end_of_text || (text_byte == ChNul)) begin
      case (phase_r)
        PH_NAME, PH_NAME_CR: if (has_r) b = add(b, K_DISCARD, ChNul);
        PH_COLON, PH_CRLF:   b = add(b, K_DONE, ChNul);
        default:             b = add(b, K_DROPPED, ChNul);
      endcase
      b         = add(b, K_ENDED, ChNul);
      phase_nxt = PH_NAME;
      has_nxt   = 1'b0;
    end else begin
      case (phase_r)
        PH_NAME: do_name = 1'b1;
        PH_NAME_CR: begin
          if (text_byte == ChLf) begin
            if (has_r) b = add(b, K_DISCARD, ChNul);
            has_nxt   = 1'b0;
            phase_nxt = PH_NAME;
          end else if (text_byte != ChCr) begin
            do_name = 1'b1;
          end
        end
        PH_COLON: begin
          if (text_byte == ChSpace)   phase_nxt = PH_VALUE;
          else if (text_byte == ChCr) phase_nxt = PH_COLON_CR;
          else                        do_value  = 1'b1;
        end
        PH_COLON_CR: begin
          if (text_byte == ChLf) phase_nxt = PH_CRLF;
          else                   do_value  = 1'b1;
        end
        PH_VALUE: do_value = 1'b1;
        PH_VALUE_CR: begin
          if (text_byte == ChLf)      phase_nxt = PH_CRLF;
          else if (text_byte != ChCr) do_value  = 1'b1;
        end
        PH_CRLF: begin
          if (blank) begin
            if (ml_r) begin
              b = add(b, K_VALUE, ChCr);
              b = add(b, K_VALUE, ChLf);
              b = add(b, K_VALUE, text_byte);
            end
            phase_nxt = PH_FOLD;
          end else begin
            b       = add(b, K_DONE, ChNul);
            has_nxt = 1'b0;
            do_name = 1'b1;
          end
        end
        PH_FOLD: begin
          if (blank) begin
            if (ml_r) b = add(b, K_VALUE, text_byte);
          end else begin
            do_value = 1'b1;
          end
        end
        default: phase_nxt = PH_NAME;
      endcase

      // a byte handed on to the name or value phase
      if (do_name) begin
        if (text_byte == ChCr) begin
          phase_nxt = PH_NAME_CR;
        end else if (text_byte == ChColon) begin
          phase_nxt = PH_COLON;
        end else begin
          b         = add(b, K_NAME, text_byte);
          has_nxt   = 1'b1;
          phase_nxt = PH_NAME;
        end
      end
      if (do_value) begin
        if (text_byte == ChCr) begin
          phase_nxt = PH_VALUE_CR;
        end else begin
          b         = add(b, K_VALUE, text_byte);
          phase_nxt = PH_VALUE;
        end
      end
    end
    bundle = b;
  end

  assign push = take && (bundle.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NAME;
      has_r   <= 1'b0;
      ml_r    <= 1'b0;
    end else begin
      if (cfg_we) ml_r <= cfg_wdata;
      if (take) begin
        phase_r <= phase_nxt;
        has_r   <= has_nxt;
      end
    end
  end

endmodule

// ===== rtl/mhfs_queue.sv =====
module mhfs_queue #(
  parameter int QDEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mhfs_pkg::bundle_t wr_data,
  input  logic              pop,
  output mhfs_pkg::bundle_t head,
  output logic              not_empty,
  output logic              full
);
  import mhfs_pkg::*;

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  bundle_t       q_r [QDEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;

  function automatic logic [AW-1:0] bump(logic [AW-1:0] p);
    return (p == AW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head      = q_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (AW+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/mhfs_back.sv =====
module mhfs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mhfs_pkg::bundle_t head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        result_kind,
  output logic [7:0]        out_byte,
  output logic              last_of_run
);
  import mhfs_pkg::*;

  logic       valid_r;
  kind_t      kind_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic [1:0] idx_r;
  logic       load, at_last;

  assign load    = head_valid && (!valid_r || out_ready);
  assign at_last = (idx_r == (head.cnt - 2'd1));
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load)           valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
      if (load) idx_r <= at_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= head.kind[idx_r];
      byte_r <= head.data[idx_r];
      last_r <= at_last;
    end
  end

  assign out_valid   = valid_r;
  assign result_kind = kind_r;
  assign out_byte    = byte_r;
  assign last_of_run = last_r;

endmodule

// ===== rtl/mail_header_field_splitter.sv =====
// Mail header field splitter.
// in_if carries one byte of header text per request (text_byte, end_of_text);
// a zero byte or end_of_text closes the text. out_if carries results one per
// request: result_kind, out_byte and last_of_run on the final result of an
// input byte. Name bytes, value bytes, field complete, discard name, value
// dropped and text ended are the result kinds. Bytes that cause no result
// (CR, the space after a colon, folding blanks without multiline_ok) produce no output request.
// cfg_we/cfg_wdata write multiline_ok; the user must do so only while the block
// is idle, which the block itself leaves unchecked. Throughput: one input byte per
// cycle while the queue has room; results leave at one per cycle while the
// receiver is ready, so a byte that makes two or three results (fold with
// multiline_ok, end of text) is soaked up by the QDEPTH-entry result queue. The
// parser is combinational and writes the queue; the output register follows it.
// in_if.ready drops only when the queue is full; a stalled receiver fills the
// queue and then back-pressures the input. The output register holds its
// result until taken.
// Reset (synchronous, rst_n low): parser to name phase, multiline_ok to 0,
// queue and output register empty.
module mail_header_field_splitter #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  mhfs_in_if.sink    in_if,
  mhfs_out_if.source out_if
);
  import mhfs_pkg::*;

  bundle_t bundle, head;
  logic    push, pop, q_full, q_not_empty, take;

  // byte accepted whenever the queue has a free slot
  assign in_if.ready = !q_full;
  assign take        = in_if.valid && !q_full;

  mhfs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .take        (take),
    .text_byte   (in_if.text_byte),
    .end_of_text (in_if.end_of_text),
    .push        (push),
    .bundle      (bundle)
  );

  mhfs_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (bundle),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // serializes each queued bundle onto the output, one result a cycle while out_if is ready
  mhfs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .head_valid  (q_not_empty),
    .pop         (pop),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .result_kind (out_if.result_kind),
    .out_byte    (out_if.out_byte),
    .last_of_run (out_if.last_of_run)
  );

endmodule
